@@ rtl/signed_feature_hasher_top_assert.svh @@
// assertion macros used by the signed feature hasher checker
// depends on nothing; included by files that hold concurrent assertions
`ifndef SIGNED_FEATURE_HASHER_TOP_ASSERT_SVH
`define SIGNED_FEATURE_HASHER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is high
`define SHF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define SHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset itself
`define SHF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/shf_pkg.sv @@
// shared types, constants and helper functions of the signed feature hasher
// depends on nothing; used by every rtl module through scoped names
`default_nettype none

package shf_pkg;

   // field widths
   localparam int IndexWidth = 31;
   localparam int ValueWidth = 64;
   localparam int SeedWidth  = 32;
   localparam int HashWidth  = 32;

   // key length in bytes and full 4-byte blocks
   localparam int IndexBytes = 4;
   localparam int IdxBlocks  = IndexBytes / 4;

   // murmur3 x86_32 constants
   localparam logic [HashWidth-1:0] MhC1       = 32'hcc9e2d51;
   localparam logic [HashWidth-1:0] MhC2       = 32'h1b873593;
   localparam logic [HashWidth-1:0] MhRoundAdd = 32'he6546b64;
   localparam logic [HashWidth-1:0] MhFmix1    = 32'h85ebca6b;
   localparam logic [HashWidth-1:0] MhFmix2    = 32'hc2b2ae35;
   localparam logic [HashWidth-1:0] MhLen      = 32'(IndexBytes);

   // pipeline geometry
   localparam int HashStages = 6;
   localparam int DivSteps   = 2;
   localparam int DivStages  = (IndexWidth + DivSteps - 1) / DivSteps;

   // data that rides along with a request
   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  negated;
      logic                  last;
   } side_type;

   // hash unit to divider
   typedef struct packed {
      logic                 valid;
      logic [HashWidth-1:0] hash;
      side_type             side;
   } hash_out_type;

   // divider to response port
   typedef struct packed {
      logic                  valid;
      logic [IndexWidth-1:0] remainder;
      side_type              side;
   } div_out_type;

   // low 32 bits of a 32x32 product
   function automatic logic [HashWidth-1:0] mul32(input logic [HashWidth-1:0] a,
                                                  input logic [HashWidth-1:0] b);
      logic [2*HashWidth-1:0] p;
      p = 64'(a) * 64'(b);
      return p[HashWidth-1:0];
   endfunction

   // body round: rotl 13, times 5, plus constant
   function automatic logic [HashWidth-1:0] hash_round(input logic [HashWidth-1:0] h);
      logic [HashWidth-1:0] t;
      t = {h[18:0], h[31:19]};
      return t + {t[29:0], 2'b00} + MhRoundAdd;
   endfunction

   // one restoring remainder step
   function automatic logic [IndexWidth-1:0] rem_step(input logic [IndexWidth-1:0] r,
                                                      input logic                  b,
                                                      input logic [IndexWidth-1:0] d);
      logic [IndexWidth:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[IndexWidth-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/shf_hash.sv @@
// six-stage murmur3 x86_32 hash of the 31-bit index, sign flip of the value
// depends on shf_pkg
`default_nettype none

module shf_hash (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              adv,
   input  wire logic                              in_valid,
   input  wire logic [shf_pkg::IndexWidth-1:0]    in_index,
   input  wire logic [shf_pkg::ValueWidth-1:0]    in_value,
   input  wire logic [shf_pkg::SeedWidth-1:0]     in_seed,
   input  wire logic                              in_last,
   output shf_pkg::hash_out_type                  out
);

   logic [shf_pkg::HashStages-1:0] vld_ff, vld_in;
   shf_pkg::side_type              side_ff [shf_pkg::HashStages];
   shf_pkg::side_type              side_in [shf_pkg::HashStages];

   logic [shf_pkg::HashWidth-1:0]  k1_ff, k1_in;
   logic [shf_pkg::HashWidth-1:0]  k2_ff, k2_in;
   logic [shf_pkg::HashWidth-1:0]  seed1_ff, seed2_ff;
   logic [shf_pkg::HashWidth-1:0]  h3_ff, h3_in;
   logic [shf_pkg::HashWidth-1:0]  m4_ff, m4_in;
   logic [shf_pkg::HashWidth-1:0]  m5_ff, m5_in;
   logic [shf_pkg::HashWidth-1:0]  h6_ff, h6_in;

   // valid bits move with the data
   assign vld_in = {vld_ff[shf_pkg::HashStages-2:0], in_valid};

   // block mix: multiply by c1
   assign k1_in = shf_pkg::mul32(32'(in_index), shf_pkg::MhC1);

   // block mix: rotl 15, multiply by c2
   assign k2_in = shf_pkg::mul32({k1_ff[16:0], k1_ff[31:17]}, shf_pkg::MhC2);

   // fold into seed, body rounds, length
   always_comb begin
      logic [shf_pkg::HashWidth-1:0] h;
      h = shf_pkg::hash_round(seed2_ff ^ k2_ff);
      // blocks beyond the first hold only zero bytes
      for (int b = 1; b < shf_pkg::IdxBlocks; b++) begin
         h = shf_pkg::hash_round(h);
      end
      h3_in = h ^ shf_pkg::MhLen;
   end

   // finalizer
   assign m4_in = shf_pkg::mul32(h3_ff ^ {16'h0, h3_ff[31:16]}, shf_pkg::MhFmix1);
   assign m5_in = shf_pkg::mul32(m4_ff ^ {13'h0, m4_ff[31:13]}, shf_pkg::MhFmix2);
   assign h6_in = m5_ff ^ {16'h0, m5_ff[31:16]};

   // side data: captured at entry, sign applied in the last stage
   always_comb begin
      side_in[0].value   = in_value;
      side_in[0].negated = 1'b0;
      side_in[0].last    = in_last;
      for (int s = 1; s < shf_pkg::HashStages; s++) begin
         side_in[s] = side_ff[s-1];
      end
      side_in[shf_pkg::HashStages-1].negated = h6_in[0];
      side_in[shf_pkg::HashStages-1].value   =
         side_ff[shf_pkg::HashStages-2].value ^ {h6_in[0], 63'h0};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         k1_ff    <= k1_in;
         seed1_ff <= in_seed;
         k2_ff    <= k2_in;
         seed2_ff <= seed1_ff;
         h3_ff    <= h3_in;
         m4_ff    <= m4_in;
         m5_ff    <= m5_in;
         h6_ff    <= h6_in;
         for (int s = 0; s < shf_pkg::HashStages; s++) begin
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out.valid = vld_ff[shf_pkg::HashStages-1];
   assign out.hash  = h6_ff;
   assign out.side  = side_ff[shf_pkg::HashStages-1];

endmodule

`default_nettype wire

@@ rtl/shf_div.sv @@
// pipelined restoring remainder unit, two quotient bits per stage
// depends on shf_pkg; the user must hold the divisor steady while requests are in flight (not enforced here)
`default_nettype none

module shf_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  wire logic [shf_pkg::IndexWidth-1:0] dim,
   input  shf_pkg::hash_out_type               in,
   output shf_pkg::div_out_type                out
);

   localparam int Last = shf_pkg::DivStages - 1;

   logic [shf_pkg::DivStages-1:0]  vld_ff;
   logic [shf_pkg::IndexWidth-1:0] rem_ff [shf_pkg::DivStages];
   logic [shf_pkg::IndexWidth-1:0] rem_in [shf_pkg::DivStages];
   logic [shf_pkg::IndexWidth-1:0] x_ff   [shf_pkg::DivStages];
   logic [shf_pkg::IndexWidth-1:0] x_in   [shf_pkg::DivStages];
   shf_pkg::side_type              side_ff [shf_pkg::DivStages];

   for (genvar s = 0; s < shf_pkg::DivStages; s++) begin : g_stage
      logic [shf_pkg::IndexWidth-1:0] rem_prev, x_prev, rem_next, x_next;

      // dividend is hash >> 1, remainder starts at zero
      if (s == 0) begin : g_first
         assign rem_prev = '0;
         assign x_prev   = in.hash[shf_pkg::HashWidth-1:1];
      end else begin : g_rest
         assign rem_prev = rem_ff[s-1];
         assign x_prev   = x_ff[s-1];
      end

      // shift in dividend bits msb first, subtract when it fits
      always_comb begin
         logic [shf_pkg::IndexWidth-1:0] r;
         logic [shf_pkg::IndexWidth-1:0] x;
         r = rem_prev;
         x = x_prev;
         for (int t = 0; t < shf_pkg::DivSteps; t++) begin
            if (s * shf_pkg::DivSteps + t < shf_pkg::IndexWidth) begin
               r = shf_pkg::rem_step(r, x[shf_pkg::IndexWidth-1], dim);
               x = {x[shf_pkg::IndexWidth-2:0], 1'b0};
            end
         end
         rem_next = r;
         x_next   = x;
      end

      assign rem_in[s] = rem_next;
      assign x_in[s]   = x_next;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[shf_pkg::DivStages-2:0], in.valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in.side;
         for (int s = 0; s < shf_pkg::DivStages; s++) begin
            rem_ff[s] <= rem_in[s];
            x_ff[s]   <= x_in[s];
         end
         for (int s = 1; s < shf_pkg::DivStages; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out.valid     = vld_ff[Last];
   assign out.remainder = rem_ff[Last];
   assign out.side      = side_ff[Last];

endmodule

`default_nettype wire

@@ rtl/signed_feature_hasher_top.sv @@
// signed feature hasher top: 6 hash stages, then 16 remainder stages (2 bits each)
// throughput one request per cycle while the response side does not stall
// the whole pipeline stalls together while a response waits on rsp_ready
// synchronous active-high reset clears all valid bits and sets the dimension to 1
// depends on shf_pkg, shf_hash, shf_div
`default_nettype none

module signed_feature_hasher_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [shf_pkg::IndexWidth-1:0] req_original_index,
   input  wire logic [shf_pkg::ValueWidth-1:0] req_entry_value,
   input  wire logic [shf_pkg::SeedWidth-1:0]  req_hash_seed,
   input  wire logic                           req_last_in,
   // response channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [shf_pkg::IndexWidth-1:0] rsp_hashed_index,
   output      logic [shf_pkg::ValueWidth-1:0] rsp_signed_value,
   output      logic                           rsp_negated,
   output      logic                           rsp_last_out,
   // dimension register
   input  wire logic                           csr_wr_en,
   input  wire logic [shf_pkg::IndexWidth-1:0] csr_wr_data
);

   logic [shf_pkg::IndexWidth-1:0] dim_ff, dim_in;
   logic [shf_pkg::IndexWidth-1:0] dim_eff;
   logic                           adv;
   shf_pkg::hash_out_type          hash_out;
   shf_pkg::div_out_type           div_out;

   // dimension register
   assign dim_in = csr_wr_en ? csr_wr_data : dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= 31'd1;
      end else begin
         dim_ff <= dim_in;
      end
   end

   // zero dimension acts as one
   assign dim_eff = (dim_ff == '0) ? 31'd1 : dim_ff;

   // pipeline moves when the output stage is empty or being drained
   assign adv       = !div_out.valid || rsp_ready;
   assign req_ready = adv;

   shf_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_index (req_original_index),
      .in_value (req_entry_value),
      .in_seed  (req_hash_seed),
      .in_last  (req_last_in),
      .out      (hash_out)
   );

   shf_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .dim   (dim_eff),
      .in    (hash_out),
      .out   (div_out)
   );

   // response outputs
   assign rsp_valid        = div_out.valid;
   assign rsp_hashed_index = div_out.remainder;
   assign rsp_signed_value = div_out.side.value;
   assign rsp_negated      = div_out.side.negated;
   assign rsp_last_out     = div_out.side.last;

endmodule

`default_nettype wire

@@ rtl/shf_checker.sv @@
// port-level assertions for the signed feature hasher, bound to the top level
// depends on shf_pkg and signed_feature_hasher_top_assert.svh
`default_nettype none

`include "signed_feature_hasher_top_assert.svh"

module shf_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [shf_pkg::IndexWidth-1:0] req_original_index,
   input wire logic [shf_pkg::ValueWidth-1:0] req_entry_value,
   input wire logic [shf_pkg::SeedWidth-1:0]  req_hash_seed,
   input wire logic                           req_last_in,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [shf_pkg::IndexWidth-1:0] rsp_hashed_index,
   input wire logic [shf_pkg::ValueWidth-1:0] rsp_signed_value,
   input wire logic                           rsp_negated,
   input wire logic                           rsp_last_out,
   input wire logic                           csr_wr_en,
   input wire logic [shf_pkg::IndexWidth-1:0] csr_wr_data
);

   logic [shf_pkg::IndexWidth-1:0] dim_ff;
   logic [shf_pkg::IndexWidth-1:0] dim_eff;
   logic                           unused_in;

   // shadow copy of the dimension register
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= 31'd1;
      end else if (csr_wr_en) begin
         dim_ff <= csr_wr_data;
      end
   end

   assign dim_eff   = (dim_ff == '0) ? 31'd1 : dim_ff;
   assign unused_in = ^{req_valid, req_original_index, req_entry_value, req_hash_seed,
                        req_last_in};

   // stalled response holds
   `SHF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hashed_index) && $stable(rsp_signed_value)
      && $stable(rsp_negated) && $stable(rsp_last_out), "stalled response changed")

   // index always reduced below the dimension
   `SHF_ASSERT_IMPLIES(a_index_range, clock, reset, rsp_valid, rsp_hashed_index < dim_eff,
      "hashed index not below dimension")

   // request side open whenever the output stage can move
   `SHF_ASSERT_IMPLIES(a_ready_flow, clock, reset, !rsp_valid || rsp_ready, req_ready,
      "request blocked with free output stage")

   // reset empties the pipeline
   `SHF_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid,
      "response valid right after reset")

endmodule

bind signed_feature_hasher_top shf_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/tb_signed_feature_hasher_top.sv @@
`timescale 1ns / 100ps
// testbench for signed_feature_hasher_top: streams sparse feature entries and checks every
// response against an in-bench murmur3 predictor; depends on shf_pkg and the rtl top level

module tb_signed_feature_hasher_top;

   localparam int PipeLatency = 22;
   localparam int CycleLimit  = 400000;
   localparam int MaxGap      = 18;
   localparam int HoldCycles  = 300;

   // murmur3 x86_32 constants for a 4-byte key
   localparam logic [31:0] KeyMulA   = 32'hcc9e2d51;
   localparam logic [31:0] KeyMulB   = 32'h1b873593;
   localparam logic [31:0] RoundAdd  = 32'he6546b64;
   localparam logic [31:0] FinalMulA = 32'h85ebca6b;
   localparam logic [31:0] FinalMulB = 32'hc2b2ae35;
   localparam logic [31:0] KeyLength = 32'd4;

   localparam logic [30:0] DimMax    = 31'h7fffffff;
   localparam logic [30:0] IndexMax  = 31'h7fffffff;
   localparam logic [63:0] SignMask  = 64'h8000000000000000;
   localparam logic [63:0] PlusOne   = 64'h3ff0000000000000;
   localparam logic [63:0] MinusOne  = 64'hbff0000000000000;
   localparam logic [63:0] PosInf    = 64'h7ff0000000000000;
   localparam logic [63:0] NegInf    = 64'hfff0000000000000;
   localparam logic [63:0] NegZero   = 64'h8000000000000000;

   // one hashed entry as the response channel carries it
   typedef struct packed {
      logic [shf_pkg::IndexWidth-1:0] hashed_index;
      logic [shf_pkg::ValueWidth-1:0] signed_value;
      logic                           negated;
      logic                           last_out;
   } hashed_entry_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [shf_pkg::IndexWidth-1:0] req_original_index = '0;
   logic [shf_pkg::ValueWidth-1:0] req_entry_value = '0;
   logic [shf_pkg::SeedWidth-1:0]  req_hash_seed = '0;
   logic                           req_last_in = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [shf_pkg::IndexWidth-1:0] rsp_hashed_index;
   logic [shf_pkg::ValueWidth-1:0] rsp_signed_value;
   logic                           rsp_negated;
   logic                           rsp_last_out;
   logic                           csr_wr_en = 1'b0;
   logic [shf_pkg::IndexWidth-1:0] csr_wr_data = '0;

   // predictor state and bookkeeping
   logic [30:0]      dimension_setting = 31'd1;
   hashed_entry_type pending_results[$];
   hashed_entry_type oldest_result;
   logic [31:0]      class_seeds[8];
   int unsigned      req_gap_max = 0;
   int unsigned      rsp_gap_max = 0;
   int unsigned      rsp_hold_cycles = 0;
   int unsigned      cycle_count = 0;
   int unsigned      input_stall_cycles = 0;
   int unsigned      accepted_count = 0;
   int unsigned      response_count = 0;
   int unsigned      dimension_writes = 0;
   int unsigned      error_count = 0;

   signed_feature_hasher_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_original_index (req_original_index),
      .req_entry_value    (req_entry_value),
      .req_hash_seed      (req_hash_seed),
      .req_last_in        (req_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hashed_index   (rsp_hashed_index),
      .rsp_signed_value   (rsp_signed_value),
      .rsp_negated        (rsp_negated),
      .rsp_last_out       (rsp_last_out),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // murmur3 x86_32 of the index as four little-endian bytes
   function automatic logic [31:0] murmur3_index_hash(input logic [30:0] idx,
                                                      input logic [31:0] seed);
      logic [31:0] k;
      logic [31:0] h;
      k = {1'b0, idx} * KeyMulA;
      k = rotate_left(k, 15);
      k = k * KeyMulB;
      h = rotate_left(seed ^ k, 13);
      h = h * 32'd5 + RoundAdd;
      h = h ^ KeyLength;
      h = h ^ (h >> 16);
      h = h * FinalMulA;
      h = h ^ (h >> 13);
      h = h * FinalMulB;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // expected response under the current dimension; zero acts as one
   function automatic hashed_entry_type predict_hashed_entry(input logic [30:0] idx,
                                                             input logic [63:0] val,
                                                             input logic [31:0] seed,
                                                             input logic        last);
      logic [31:0]      h;
      logic [31:0]      modulus;
      hashed_entry_type r;
      h = murmur3_index_hash(idx, seed);
      modulus = (dimension_setting == '0) ? 32'd1 : {1'b0, dimension_setting};
      r.hashed_index = 31'((h >> 1) % modulus);
      r.negated      = h[0];
      r.signed_value = h[0] ? (val ^ SignMask) : val;
      r.last_out     = last;
      return r;
   endfunction

   // random double bits, with infinities, nans, zeros, subnormals and +-1.0 mixed in
   function automatic logic [63:0] random_entry_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = {v[63], 11'h7ff, 52'h0};
         1: v = {v[63], 11'h7ff, v[51:0] | 52'h1};
         2: v = {v[63], 63'h0};
         3: v = {v[63], 11'h000, v[51:0]};
         4: v = v[63] ? MinusOne : PlusOne;
         default: ;
      endcase
      return v;
   endfunction

   // offer one request after a random gap, hold it until accepted
   task automatic send_request(input logic [30:0] idx, input logic [63:0] val,
                               input logic [31:0] seed, input logic last);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_original_index <= idx;
      req_entry_value    <= val;
      req_hash_seed      <= seed;
      req_last_in        <= last;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_hashed_entry(idx, val, seed, last));
      accepted_count++;
   endtask

   // stop offering and let every outstanding request come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PipeLatency + 4) @(posedge clock);
   endtask

   // dimension register write, only with the pipeline empty
   task automatic write_dimension(input logic [30:0] dim);
      wait_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dim;
      @(posedge clock);
      dimension_setting = dim;
      dimension_writes++;
      csr_wr_en <= 1'b0;
   endtask

   // streams of sparse vectors sharing a class seed, with some noise entries
   task automatic run_random_phase(input logic [30:0] dim, input int unsigned count,
                                   input int unsigned req_max, input int unsigned rsp_max);
      int unsigned sent;
      int unsigned len;
      logic [30:0] next_index;
      logic [31:0] seed;
      write_dimension(dim);
      req_gap_max = req_max;
      rsp_gap_max = rsp_max;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 6) == 0) begin
            send_request(31'($urandom), random_entry_value(), $urandom,
                         1'($urandom_range(0, 1)));
            sent++;
         end else begin
            len = $urandom_range(1, 12);
            next_index = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                     : 31'($urandom_range(0, 2000));
            seed = class_seeds[$urandom_range(0, 7)];
            for (int j = 0; j < len; j++) begin
               send_request(next_index, random_entry_value(), seed, j == len - 1);
               next_index = next_index + 31'($urandom_range(1, 40));
               sent++;
            end
         end
      end
   endtask

   // dimension straight out of reset is one, so every index lands on zero
   task automatic test_reset_dimension();
      send_request(31'd0, PlusOne, 32'd0, 1'b0);
      send_request(IndexMax, MinusOne, 32'hffffffff, 1'b1);
      send_request(31'd12345, {$urandom, $urandom}, $urandom, 1'b0);
   endtask

   // field extremes and special doubles under the full-range dimension, then one under dimension one
   task automatic test_directed_cases();
      write_dimension(DimMax);
      send_request(31'd0, 64'h0, 32'd0, 1'b0);
      send_request(IndexMax, NegZero, 32'hffffffff, 1'b1);
      send_request(31'h55555555, PosInf, 32'haaaaaaaa, 1'b0);
      send_request(31'h2aaaaaaa, NegInf, 32'h55555555, 1'b1);
      send_request(31'd1, 64'h7ff0000000000001, 32'd1, 1'b0);
      send_request(31'd2, 64'hfff8deadbeef0000, 32'h80000000, 1'b0);
      send_request(31'd3, 64'hffffffffffffffff, 32'h7fffffff, 1'b1);
      send_request(31'h40000000, 64'h7fefffffffffffff, 32'd42, 1'b0);
      send_request(31'd7, 64'h0000000000000001, 32'd42, 1'b1);
      send_request(31'd8, PlusOne, 32'hdeadbeef, 1'b0);
      send_request(31'd9, MinusOne, 32'hdeadbeef, 1'b1);
      write_dimension(31'd1);
      send_request(IndexMax, 64'h8000000000000001, 32'hffffffff, 1'b1);
   endtask

   // a zero dimension is treated as one
   task automatic test_zero_dimension();
      write_dimension(31'd0);
      for (int i = 0; i < 6; i++) begin
         send_request(31'($urandom), random_entry_value(), $urandom, 1'(i == 5));
      end
   endtask

   // random traffic across a spread of dimensions and idling mixes
   task automatic test_random_sparse_vectors();
      run_random_phase(31'd1, 80, 0, 0);
      run_random_phase(31'd2, 80, MaxGap, MaxGap);
      run_random_phase(31'd3, 80, 0, MaxGap);
      run_random_phase(31'd7, 80, MaxGap, 0);
      run_random_phase(31'd1000, 80, 3, 3);
      run_random_phase(31'h10000, 80, 0, 0);
      run_random_phase(31'h40000000, 80, MaxGap, MaxGap);
      run_random_phase(DimMax, 80, 3, MaxGap);
      run_random_phase(31'($urandom_range(1, 5000)), 80, MaxGap, 3);
      run_random_phase(31'($urandom), 80, 0, 3);
      run_random_phase(31'd0, 60, 3, 0);
   endtask

   // long response hold while requests keep coming back to back
   task automatic test_input_backpressure();
      write_dimension(31'd977);
      req_gap_max = 0;
      rsp_gap_max = 0;
      rsp_hold_cycles = HoldCycles;
      for (int i = 0; i < 80; i++) begin
         send_request(31'($urandom_range(0, 5000)), random_entry_value(), class_seeds[i % 8],
                      1'(i % 10 == 9));
      end
   endtask

   // sender stops until everything is back, then resumes
   task automatic test_sender_pause();
      req_gap_max = 3;
      rsp_gap_max = MaxGap;
      for (int i = 0; i < 30; i++) begin
         send_request(31'($urandom), random_entry_value(), $urandom, 1'(i == 29));
      end
      wait_until_drained();
      for (int i = 0; i < 30; i++) begin
         send_request(31'($urandom), random_entry_value(), $urandom, 1'(i == 29));
      end
   endtask

   // response side: random stalls per response, plus an occasional long hold
   initial begin
      int unsigned gap;
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && rsp_hold_cycles == 0);
      end
   end

   task automatic check_field(input string field_name, input logic [63:0] expected,
                              input logic [63:0] actual);
      if (actual !== expected) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field_name,
                  expected, actual);
         error_count++;
      end
   endtask

   // compare each accepted response with the oldest pending prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: response with no pending request, index %0d value %h",
                     $time, rsp_hashed_index, rsp_signed_value);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            response_count++;
            check_field("hashed_index", 64'(oldest_result.hashed_index), 64'(rsp_hashed_index));
            check_field("signed_value", oldest_result.signed_value, rsp_signed_value);
            check_field("negated", 64'(oldest_result.negated), 64'(rsp_negated));
            check_field("last_out", 64'(oldest_result.last_out), 64'(rsp_last_out));
         end
      end
   end

   // cycle watchdog and input stall count
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && !req_ready) begin
         input_stall_cycles++;
      end
      if (cycle_count > CycleLimit) begin
         $display("%0t ns: timed out with %0d responses pending", $time,
                  pending_results.size());
         $display("[signed_feature_hasher_top] ERROR");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (class_seeds[i]) begin
         class_seeds[i] = $urandom;
      end
      class_seeds[0] = 32'd0;
      class_seeds[1] = 32'hffffffff;
      test_reset_dimension();
      test_directed_cases();
      test_zero_dimension();
      test_random_sparse_vectors();
      test_input_backpressure();
      test_sender_pause();
      wait_until_drained();
      $display("hashed %0d entries, %0d responses checked, %0d dimension writes incl. 0, 1, max",
               accepted_count, response_count, dimension_writes);
      $display("request side stalled %0d cycles under response hold; %0d mismatches",
               input_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("[signed_feature_hasher_top] OK");
      end else begin
         $display("[signed_feature_hasher_top] ERROR");
      end
      $finish;
   end

endmodule
